// ----- rtl/core/bsm_pkg.sv -----
// Package for the radix-2 Booth signed multiplier.
// Holds the operand width, Booth pair codes and controller-to-datapath command type.
// No dependencies.
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int unsigned Width   = 8;
  localparam int unsigned ProdW   = 2 * Width;
  localparam int unsigned CntW    = (Width > 1) ? $clog2(Width) : 1;
  // a load step plus one add-and-shift step per multiplier bit
  localparam int unsigned Latency = Width + 1;

  // Booth pair {q0, previous bit}
  localparam logic [1:0] PAIR_SUB = 2'b10;
  localparam logic [1:0] PAIR_ADD = 2'b01;

  typedef struct packed {
    logic load;  // capture operands, clear accumulator
    logic step;  // one add/sub and arithmetic shift
  } bsm_cmd_t;

endpackage

// ----- rtl/core/bsm_ctrl.sv -----
// Controller for the Booth multiplier: idle/run/done sequencer and step counter.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_ctrl
  import bsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     valid_o,
  output bsm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } bsm_state_e;

  bsm_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            last_step;

  assign busy_o    = (state_q == ST_RUN);
  assign valid_o   = (state_q == ST_DONE);
  assign accept    = start_i && !busy_o;
  assign last_step = (cnt_q == CntW'(Width - 1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_RUN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/bsm_datapath.sv -----
// Datapath for the Booth multiplier: guarded accumulator, multiplier shift
// register and previous bit. Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_datapath
  import bsm_pkg::*;
(
  input  logic             clk_i,
  input  bsm_cmd_t         cmd_i,
  input  logic [Width-1:0] multiplicand_i,
  input  logic [Width-1:0] multiplier_i,
  output logic [ProdW-1:0] product_o
);

  logic [Width:0]   mcand_q;   // sign-extended by one guard bit
  logic [Width:0]   acc_q;
  logic [Width-1:0] mplier_q;
  logic             prev_q;
  logic [Width:0]   sum;

  always_comb begin
    case ({mplier_q[0], prev_q})
      PAIR_SUB: sum = acc_q - mcand_q;
      PAIR_ADD: sum = acc_q + mcand_q;
      default:  sum = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mcand_q  <= {multiplicand_i[Width-1], multiplicand_i};
      acc_q    <= '0;
      mplier_q <= multiplier_i;
      prev_q   <= 1'b0;
    end else if (cmd_i.step) begin
      // {acc, mplier} shifts right arithmetically as one word
      acc_q    <= {sum[Width], sum[Width:1]};
      mplier_q <= {sum[0], mplier_q[Width-1:1]};
      prev_q   <= mplier_q[0];
    end
  end

  assign product_o = {acc_q[Width-1:0], mplier_q};

endmodule

// ----- rtl/core/booth_signed_multiplier.sv -----
// Top level of the radix-2 Booth signed multiplier.
// Instantiates bsm_ctrl and bsm_datapath; depends on bsm_pkg.
`timescale 1ns / 1ps
//
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------
// input    | start, busy          | multiplicand_i, multiplier_i (signed)
// result   | valid_o (1 cycle)    | product_o (signed, 2*Width bits)
//
// An item is taken at the edge where start is high and busy is low. That edge
// loads the operands; the shared add/sub unit then runs one Booth step per
// multiplier bit, with busy high. valid_o and product_o show the result in the
// cycle after the last step; start is taken in that same cycle.
// Reset (async, active low) returns the controller to idle; the datapath
// registers are not reset. The result cannot be stalled: it is shown once.

module booth_signed_multiplier
  import bsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [Width-1:0] multiplicand_i,
  input  logic [Width-1:0] multiplier_i,
  output logic             valid_o,
  output logic [ProdW-1:0] product_o
);

  bsm_cmd_t cmd;

  // sequencer: accept, step count, result strobe
  bsm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  // accumulator and multiplier shift register; product read straight from them
  bsm_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .multiplicand_i (multiplicand_i),
    .multiplier_i   (multiplier_i),
    .product_o      (product_o)
  );

endmodule

// ----- rtl/core/bsm_checker.sv -----
// Port-level checks for booth_signed_multiplier, bound to the top level.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_checker
  import bsm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [Width-1:0] multiplicand_i,
  input logic [Width-1:0] multiplier_i,
  input logic             valid_o,
  input logic [ProdW-1:0] product_o
);

  logic             accept;
  logic [ProdW-1:0] expect_prod;

  assign accept      = start && !busy;
  assign expect_prod = ProdW'($signed(multiplicand_i) * $signed(multiplier_i));

  a_valid_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("item accepted but not busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency valid_o) else $error("result not on time");

  a_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency (product_o == $past(expect_prod, Latency)))
    else $error("wrong product");

endmodule

bind booth_signed_multiplier bsm_checker u_bsm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .multiplicand_i (multiplicand_i),
  .multiplier_i   (multiplier_i),
  .valid_o        (valid_o),
  .product_o      (product_o)
);
